// ===== hw/rtl/abf_pkg.sv =====
`timescale 1ns / 1ps

package abf_pkg;

	// store and stream sizes
	localparam int PATTERN_DEPTH  = 64;
	localparam int PAT_AW         = $clog2(PATTERN_DEPTH);
	localparam int MAX_DATA_BYTES = 255;
	localparam int MANUF_MAX      = 32;
	localparam int NAME_MAX       = 63;

	// item operations
	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_HEADER = 2'd1;
	localparam logic [1:0] OP_DATA   = 2'd2;

	// match modes
	localparam logic [2:0] MODE_ADDR   = 3'd0;
	localparam logic [2:0] MODE_EXACT  = 3'd1;
	localparam logic [2:0] MODE_PREFIX = 3'd2;
	localparam logic [2:0] MODE_UUID   = 3'd3;
	localparam logic [2:0] MODE_MANUF  = 3'd4;

	// register indexes
	localparam logic [1:0] REG_MODE = 2'd0;
	localparam logic [1:0] REG_RSSI = 2'd1;
	localparam logic [1:0] REG_PLEN = 2'd2;

	// advertising field types
	localparam logic [7:0] AD_NAME_SHORT = 8'h08;
	localparam logic [7:0] AD_NAME_FULL  = 8'h09;
	localparam logic [7:0] AD_UUID16_A   = 8'h02;
	localparam logic [7:0] AD_UUID16_B   = 8'h03;
	localparam logic [7:0] AD_UUID128_A  = 8'h06;
	localparam logic [7:0] AD_UUID128_B  = 8'h07;
	localparam logic [7:0] AD_MANUF      = 8'hff;

	typedef struct packed {
		logic [2:0]        mode;
		logic signed [7:0] rssi_floor;
		logic [6:0]        plen;
	} cfg_t;

	// prefetched store bytes for the next data beat
	typedef struct packed {
		logic [7:0] pat_a;
		logic [7:0] msk_a;
		logic [7:0] pat_b;
		logic       addr_eq;
	} lookup_t;

	// uuid chunk width from the pattern length, zero when unusable
	function automatic logic [4:0] uuid_width(input logic [6:0] plen);
		logic [4:0] w;
		begin
			if (plen == 7'd2) begin
				w = 5'd2;
			end else if (plen == 7'd16) begin
				w = 5'd16;
			end else begin
				w = 5'd0;
			end
			return w;
		end
	endfunction

endpackage

// ===== hw/rtl/ble_advertisement_filter.sv =====
`timescale 1ns / 1ps

// BLE advertisement filter.
// Item channel (item_valid/item_ready): load beats fill the pattern and mask
// store, a header beat opens an advertisement, data beats carry its bytes.
// Result channel (result_valid/result_ready): one matched bit per
// advertisement, after its last data byte, or after the header when the
// length is zero. Load beats and ignored beats give no result.
// One item is accepted every cycle unless a waiting result blocks it; a result
// is valid in the cycle after the beat that causes it. The store has registered
// reads, so the entries for the next data byte are fetched in the cycle that
// updates the parse state. The result register frees the item side: an item is
// taken whenever the result register is empty or is being drained in the same
// cycle, so a receiver stall blocks items only while a result is waiting.
// Reset clears the parse state and the registers (mode address, minimum
// rssi -128, pattern length 0); store contents are undefined until loaded.
// Registers sit on the APB port at 0x0, 0x4 and 0x8; write them only while
// no advertisement result is outstanding.

module ble_advertisement_filter (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              item_valid,
	output logic              item_ready,
	input  logic [1:0]        operation,
	input  logic [5:0]        pattern_index,
	input  logic [7:0]        pattern_value,
	input  logic [7:0]        mask_value,
	input  logic [47:0]       adv_address,
	input  logic signed [7:0] adv_rssi,
	input  logic [7:0]        adv_length,
	input  logic [7:0]        data_byte,
	output logic              result_valid,
	input  logic              result_ready,
	output logic              matched
);

	abf_pkg::cfg_t    cfg_q;
	abf_pkg::cfg_t    cfg_d;
	abf_pkg::lookup_t lk;
	logic             cfg_wr;
	logic [1:0]       reg_idx;
	logic             accept;
	logic [7:0]       vp_next;
	logic             res_fire;
	logic             res_matched;
	logic             result_valid_q;
	logic             matched_q;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite;

	// register writes
	always_comb begin
		cfg_d = cfg_q;
		if (cfg_wr) begin
			unique case (reg_idx)
				abf_pkg::REG_MODE: cfg_d.mode       = pwdata[2:0];
				abf_pkg::REG_RSSI: cfg_d.rssi_floor = pwdata[7:0];
				abf_pkg::REG_PLEN: cfg_d.plen       = pwdata[6:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode       <= abf_pkg::MODE_ADDR;
			cfg_q.rssi_floor <= -8'sd128;
			cfg_q.plen       <= '0;
		end else begin
			cfg_q <= cfg_d;
		end
	end

	// register reads
	always_comb begin
		unique case (reg_idx)
			abf_pkg::REG_MODE: prdata = {29'd0, cfg_q.mode};
			abf_pkg::REG_RSSI: prdata = {{24{cfg_q.rssi_floor[7]}}, cfg_q.rssi_floor};
			abf_pkg::REG_PLEN: prdata = {25'd0, cfg_q.plen};
			default:           prdata = '0;
		endcase
	end

	assign item_ready = !result_valid_q || result_ready;
	assign accept     = item_valid && item_ready;

	abf_lookup u_lookup (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (accept && operation == abf_pkg::OP_LOAD),
		.wr_idx      (pattern_index),
		.wr_pat      (pattern_value),
		.wr_msk      (mask_value),
		.adv_address (adv_address),
		.vp_next     (vp_next),
		.cfg_next    (cfg_d),
		.lk          (lk)
	);

	abf_parse u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.operation   (operation),
		.adv_rssi    (adv_rssi),
		.adv_length  (adv_length),
		.data_byte   (data_byte),
		.cfg         (cfg_q),
		.lk          (lk),
		.vp_next     (vp_next),
		.res_fire    (res_fire),
		.res_matched (res_matched)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (res_fire) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_fire) begin
			matched_q <= res_matched;
		end
	end

	assign result_valid = result_valid_q;
	assign matched      = matched_q;

endmodule

// ===== hw/rtl/abf_lookup.sv =====
`timescale 1ns / 1ps

module abf_lookup (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [abf_pkg::PAT_AW-1:0]  wr_idx,
	input  logic [7:0]                  wr_pat,
	input  logic [7:0]                  wr_msk,
	input  logic [47:0]                 adv_address,
	input  logic [7:0]                  vp_next,
	input  abf_pkg::cfg_t               cfg_next,
	output abf_pkg::lookup_t            lk
);

	logic [7:0] pat_mem [abf_pkg::PATTERN_DEPTH];
	logic [7:0] msk_mem [abf_pkg::PATTERN_DEPTH];
	logic [7:0] addr_pat_q [6];

	logic [4:0] w;
	logic [7:0] v;
	logic [7:0] idx_a;
	logic [7:0] idx_b;
	logic       in_a;
	logic       in_b;
	logic [abf_pkg::PAT_AW-1:0] ra;
	logic [abf_pkg::PAT_AW-1:0] rb;
	logic [7:0] pat_a_q;
	logic [7:0] msk_a_q;
	logic [7:0] pat_b_q;
	logic       addr_eq;

	// read addresses for the state the next beat will see
	always_comb begin
		w = abf_pkg::uuid_width(cfg_next.plen);
		v = vp_next - 8'd1;
		if (vp_next == 8'd0) begin
			idx_a = 8'd0;
		end else if (cfg_next.mode == abf_pkg::MODE_UUID && w != 5'd0) begin
			idx_a = ({3'd0, w} - 8'd1) - (v & ({3'd0, w} - 8'd1));
		end else begin
			idx_a = v;
		end
		idx_b = vp_next;
		in_a  = {1'b0, idx_a} < 9'(abf_pkg::PATTERN_DEPTH);
		in_b  = {1'b0, idx_b} < 9'(abf_pkg::PATTERN_DEPTH);
		ra    = idx_a[abf_pkg::PAT_AW-1:0];
		rb    = idx_b[abf_pkg::PAT_AW-1:0];
	end

	// store write
	always_ff @(posedge clk) begin
		if (wr_en) begin
			pat_mem[wr_idx] <= wr_pat;
			msk_mem[wr_idx] <= wr_msk;
		end
	end

	// address pattern copy, read at fixed places
	always_ff @(posedge clk) begin
		if (wr_en && {{(8-abf_pkg::PAT_AW){1'b0}}, wr_idx} < 8'd6) begin
			addr_pat_q[wr_idx[2:0]] <= wr_pat;
		end
	end

	// registered reads with write forwarding
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_a_q <= '0;
			msk_a_q <= '0;
			pat_b_q <= '0;
		end else begin
			if (!in_a) begin
				pat_a_q <= '0;
				msk_a_q <= '0;
			end else if (wr_en && wr_idx == ra) begin
				pat_a_q <= wr_pat;
				msk_a_q <= wr_msk;
			end else begin
				pat_a_q <= pat_mem[ra];
				msk_a_q <= msk_mem[ra];
			end
			if (!in_b) begin
				pat_b_q <= '0;
			end else if (wr_en && wr_idx == rb) begin
				pat_b_q <= wr_pat;
			end else begin
				pat_b_q <= pat_mem[rb];
			end
		end
	end

	// address compare against the six pattern bytes
	always_comb begin
		addr_eq = 1'b1;
		for (int i = 0; i < 6; i++) begin
			if (adv_address[8*i +: 8] != addr_pat_q[i]) begin
				addr_eq = 1'b0;
			end
		end
	end

	assign lk.pat_a   = pat_a_q;
	assign lk.msk_a   = msk_a_q;
	assign lk.pat_b   = pat_b_q;
	assign lk.addr_eq = addr_eq;

endmodule

// ===== hw/rtl/abf_parse.sv =====
`timescale 1ns / 1ps

module abf_parse (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [1:0]        operation,
	input  logic signed [7:0] adv_rssi,
	input  logic [7:0]        adv_length,
	input  logic [7:0]        data_byte,
	input  abf_pkg::cfg_t     cfg,
	input  abf_pkg::lookup_t  lk,
	output logic [7:0]        vp_next,
	output logic              res_fire,
	output logic              res_matched
);

	typedef struct packed {
		logic found;
		logic ended;
	} name_res_t;

	logic [7:0] bp_q, dt_q, fr_q, kind_q, vp_q;
	logic       stop_q, ce_q, seen_q, ended_q, found_q, hp_q;
	logic [7:0] bp_d, dt_d, fr_d, kind_d, vp_d;
	logic       stop_d, ce_d, seen_d, ended_d, found_d, hp_d;

	logic [7:0] v;
	logic [7:0] c;
	logic [4:0] w;
	logic [7:0] wm;
	logic [7:0] ui;
	logic       is_name;
	logic       fire;
	name_res_t  nr;

	// one name character against the pattern text
	function automatic name_res_t name_cmp(input logic [8:0] i, input logic [7:0] ch,
			input logic [7:0] p_raw, input logic [6:0] plen, input logic [2:0] mode,
			input logic found_in, input logic ended_in);
		name_res_t r;
		logic [7:0] p;
		begin
			p = (i < {2'b0, plen}) ? p_raw : 8'd0;
			r.found = found_in;
			r.ended = ended_in;
			if (p == 8'd0) begin
				r.found = (mode == abf_pkg::MODE_EXACT) ? (ch == 8'd0) : 1'b1;
				r.ended = 1'b1;
			end else if (ch != p) begin
				r.found = 1'b0;
				r.ended = 1'b1;
			end
			return r;
		end
	endfunction

	// next state for the accepted beat
	always_comb begin
		bp_d = bp_q; dt_d = dt_q; fr_d = fr_q; kind_d = kind_q; vp_d = vp_q;
		stop_d = stop_q; ce_d = ce_q; seen_d = seen_q; ended_d = ended_q;
		found_d = found_q; hp_d = hp_q;
		fire = 1'b0;
		v  = vp_q - 8'd1;
		c  = ({1'b0, v} >= 9'(abf_pkg::NAME_MAX)) ? 8'd0 : data_byte;
		w  = abf_pkg::uuid_width(cfg.plen);
		wm = {3'd0, w} - 8'd1;
		ui = v & wm;
		is_name = cfg.mode == abf_pkg::MODE_EXACT || cfg.mode == abf_pkg::MODE_PREFIX;
		nr = '0;
		if (accept) begin
			unique case (operation)
				abf_pkg::OP_HEADER: begin
					hp_d   = adv_rssi >= cfg.rssi_floor;
					dt_d   = ({1'b0, adv_length} > 9'(abf_pkg::MAX_DATA_BYTES)) ?
					         8'(abf_pkg::MAX_DATA_BYTES) : adv_length;
					bp_d = '0; fr_d = '0; kind_d = '0; vp_d = '0;
					stop_d = 1'b0; seen_d = 1'b0; ended_d = 1'b0; ce_d = 1'b1;
					found_d = (cfg.mode == abf_pkg::MODE_ADDR) ? lk.addr_eq : 1'b0;
					fire = dt_d == 8'd0;
				end
				abf_pkg::OP_DATA: begin
					if (bp_q < dt_q) begin
						if (!stop_q) begin
							if (fr_q == 8'd0) begin
								if (data_byte == 8'd0 ||
								    ({1'b0, bp_q} + {1'b0, data_byte}) >= {1'b0, dt_q}) begin
									stop_d = 1'b1;
								end else begin
									fr_d = data_byte;
									vp_d = 8'd0;
								end
							end else begin
								fr_d = fr_q - 8'd1;
								if (vp_q == 8'd0) begin
									// type byte
									kind_d = data_byte;
									if (is_name) begin
										if ((data_byte == abf_pkg::AD_NAME_SHORT ||
										     data_byte == abf_pkg::AD_NAME_FULL) && !seen_q) begin
											seen_d  = 1'b1;
											ended_d = 1'b0;
											if (fr_d == 8'd0) begin
												nr = name_cmp(9'd0, 8'd0, lk.pat_a, cfg.plen,
												              cfg.mode, found_q, 1'b0);
												found_d = nr.found;
												ended_d = nr.ended;
											end
										end
									end else if (cfg.mode == abf_pkg::MODE_UUID ||
									             cfg.mode == abf_pkg::MODE_MANUF) begin
										ce_d = 1'b1;
									end
								end else if (is_name) begin
									// name character
									if ((kind_q == abf_pkg::AD_NAME_SHORT ||
									     kind_q == abf_pkg::AD_NAME_FULL) && seen_q && !ended_q) begin
										nr = name_cmp({1'b0, v}, c, lk.pat_a, cfg.plen, cfg.mode,
										              found_q, ended_q);
										if (!nr.ended && fr_d == 8'd0) begin
											nr = name_cmp({1'b0, v} + 9'd1, 8'd0, lk.pat_b,
											              cfg.plen, cfg.mode, nr.found, nr.ended);
										end
										found_d = nr.found;
										ended_d = nr.ended;
									end
								end else if (cfg.mode == abf_pkg::MODE_UUID) begin
									// uuid chunk byte
									if ((w == 5'd2 && (kind_q == abf_pkg::AD_UUID16_A ||
									                   kind_q == abf_pkg::AD_UUID16_B)) ||
									    (w == 5'd16 && (kind_q == abf_pkg::AD_UUID128_A ||
									                    kind_q == abf_pkg::AD_UUID128_B))) begin
										ce_d = (ui == 8'd0) ? 1'b1 : ce_q;
										if (data_byte != lk.pat_a) begin
											ce_d = 1'b0;
										end
										if (ui == wm && ce_d) begin
											found_d = 1'b1;
										end
									end
								end else if (cfg.mode == abf_pkg::MODE_MANUF) begin
									// manufacturer data byte
									if (cfg.plen >= 7'd1 && cfg.plen <= 7'(abf_pkg::MANUF_MAX) &&
									    kind_q == abf_pkg::AD_MANUF && {1'b0, v} < {2'b0, cfg.plen}) begin
										if ((data_byte & lk.msk_a) != (lk.pat_a & lk.msk_a)) begin
											ce_d = 1'b0;
										end
										if ({1'b0, v} == {2'b0, cfg.plen} - 9'd1 && ce_d) begin
											found_d = 1'b1;
										end
									end
								end
								vp_d = vp_q + 8'd1;
							end
						end
						bp_d = bp_q + 8'd1;
						fire = bp_d == dt_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bp_q <= '0; dt_q <= '0; fr_q <= '0; kind_q <= '0; vp_q <= '0;
			stop_q <= 1'b0; ce_q <= 1'b1; seen_q <= 1'b0; ended_q <= 1'b0;
			found_q <= 1'b0; hp_q <= 1'b0;
		end else begin
			bp_q <= bp_d; dt_q <= dt_d; fr_q <= fr_d; kind_q <= kind_d; vp_q <= vp_d;
			stop_q <= stop_d; ce_q <= ce_d; seen_q <= seen_d; ended_q <= ended_d;
			found_q <= found_d; hp_q <= hp_d;
		end
	end

	assign vp_next     = vp_d;
	assign res_fire    = fire;
	assign res_matched = hp_d && found_d && cfg.mode <= abf_pkg::MODE_MANUF;

endmodule

// ===== hw/rtl/abf_checker.sv =====
`timescale 1ns / 1ps

module abf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       item_valid,
	input logic       item_ready,
	input logic [1:0] operation,
	input logic [7:0] adv_length,
	input logic       result_valid,
	input logic       result_ready,
	input logic       matched,
	input logic       pready
);

	// a waiting result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(matched))
		else $error("result beat changed while stalled");

	// a new result only follows an accepted item
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_valid && item_ready))
		else $error("result without an item");

	// a load beat gives no result
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && operation == abf_pkg::OP_LOAD &&
		!(result_valid && !result_ready) |=> !result_valid)
		else $error("load beat gave a result");

	// an empty advertisement gives its verdict next cycle
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && operation == abf_pkg::OP_HEADER &&
		adv_length == 8'd0 |=> result_valid)
		else $error("empty advertisement without verdict");

	// items are refused only while a result waits
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> result_valid && !result_ready && pready)
		else $error("item side stalled without cause");

endmodule

bind ble_advertisement_filter abf_checker u_abf_checker (.*);

// ===== test/ble_advertisement_filter_tb.sv =====
`timescale 1ns / 1ps

module ble_advertisement_filter_tb;
	import abf_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int LONG_HOLD   = 300;
	localparam int SETTLE      = 6;
	localparam int ITEM_GOAL   = 700;

	typedef struct {
		logic [1:0]        op;
		logic [5:0]        idx;
		logic [7:0]        pv;
		logic [7:0]        mv;
		logic [47:0]       addr;
		logic signed [7:0] rssi;
		logic [7:0]        len;
		logic [7:0]        db;
	} beat_t;

	// filter predictor and store of expected verdicts
	class verdict_board;
		logic [7:0]        pat [PATTERN_DEPTH];
		logic [7:0]        msk [PATTERN_DEPTH];
		int unsigned       pos, total, remain, kind, vpos;
		bit                stopped, chunk_eq, name_seen, name_ended, found, hdr_pass;
		logic [2:0]        mode;
		logic signed [7:0] rssi_floor;
		logic [6:0]        plen;
		bit                verdicts [$];
		int                errors;

		function new();
			mode = MODE_ADDR;
			rssi_floor = -8'sd128;
			plen = 7'd0;
			chunk_eq = 1'b1;
			errors = 0;
		endfunction

		task report(string what);
			$display("error at %0t: %s", $realtime, what);
			errors++;
		endtask

		function void write_reg(logic [1:0] r, logic [31:0] v);
			case (r)
				REG_MODE: mode = v[2:0];
				REG_RSSI: rssi_floor = v[7:0];
				REG_PLEN: plen = v[6:0];
				default: ;
			endcase
		endfunction

		function int unsigned pat_at(int unsigned i);
			return i < PATTERN_DEPTH ? int'(pat[i]) : 0;
		endfunction

		function int unsigned msk_at(int unsigned i);
			return i < PATTERN_DEPTH ? int'(msk[i]) : 0;
		endfunction

		// one name character against the pattern text, zero means end of name
		function void name_step(int unsigned i, int unsigned c);
			int unsigned p;
			p = i < plen ? pat_at(i) : 0;
			if (p == 0) begin
				found = (mode == MODE_EXACT) ? (c == 0) : 1'b1;
				name_ended = 1'b1;
			end else if (c != p) begin
				found = 1'b0;
				name_ended = 1'b1;
			end
		endfunction

		function void type_byte(int unsigned b);
			if (mode == MODE_EXACT || mode == MODE_PREFIX) begin
				if ((b == AD_NAME_SHORT || b == AD_NAME_FULL) && !name_seen) begin
					name_seen = 1'b1;
					name_ended = 1'b0;
					if (remain == 0) name_step(0, 0);
				end
			end else if (mode == MODE_UUID || mode == MODE_MANUF) begin
				chunk_eq = 1'b1;
			end
		endfunction

		function void value_byte(int unsigned v, int unsigned b);
			int unsigned w, i, n;
			bit ok;
			if (mode == MODE_EXACT || mode == MODE_PREFIX) begin
				if ((kind == AD_NAME_SHORT || kind == AD_NAME_FULL) && name_seen && !name_ended) begin
					name_step(v, v >= NAME_MAX ? 0 : b);
					if (!name_ended && remain == 0) name_step(v + 1, 0);
				end
			end else if (mode == MODE_UUID) begin
				w = plen == 2 ? 2 : (plen == 16 ? 16 : 0);
				ok = (w == 2 && (kind == AD_UUID16_A || kind == AD_UUID16_B)) ||
					(w == 16 && (kind == AD_UUID128_A || kind == AD_UUID128_B));
				if (ok) begin
					i = v & (w - 1);
					if (i == 0) chunk_eq = 1'b1;
					if (b != pat_at(w - 1 - i)) chunk_eq = 1'b0;
					if (i == w - 1 && chunk_eq) found = 1'b1;
				end
			end else if (mode == MODE_MANUF) begin
				n = plen;
				if (n >= 1 && n <= MANUF_MAX && kind == AD_MANUF && v < n) begin
					if ((b & msk_at(v)) != (pat_at(v) & msk_at(v))) chunk_eq = 1'b0;
					if (v == n - 1 && chunk_eq) found = 1'b1;
				end
			end
		endfunction

		function bit verdict();
			return hdr_pass && found && mode <= MODE_MANUF;
		endfunction

		// accepted item beat
		function void note(beat_t it);
			int unsigned b;
			case (it.op)
				OP_LOAD: begin
					pat[it.idx] = it.pv;
					msk[it.idx] = it.mv;
				end
				OP_HEADER: begin
					hdr_pass = it.rssi >= rssi_floor;
					total = it.len;
					pos = 0; remain = 0; kind = 0; vpos = 0;
					stopped = 0; name_seen = 0; name_ended = 0; found = 0;
					chunk_eq = 1'b1;
					if (mode == MODE_ADDR)
						found = it.addr == {pat[5], pat[4], pat[3], pat[2], pat[1], pat[0]};
					if (total == 0) verdicts.push_back(verdict());
				end
				OP_DATA: begin
					b = it.db;
					if (pos < total) begin
						if (!stopped) begin
							if (remain == 0) begin
								if (b == 0 || pos + b >= total) begin
									stopped = 1'b1;
								end else begin
									remain = b;
									vpos = 0;
								end
							end else begin
								remain--;
								if (vpos == 0) begin
									kind = b;
									type_byte(b);
								end else begin
									value_byte(vpos - 1, b);
								end
								vpos = (vpos + 1) & 8'hff;
							end
						end
						pos++;
						if (pos == total) verdicts.push_back(verdict());
					end
				end
				default: ;
			endcase
		endfunction

		// accepted result beat
		task check(bit m);
			bit want;
			if (verdicts.size() == 0) begin
				report($sformatf("unexpected result matched=%0d", m));
			end else begin
				want = verdicts.pop_front();
				if (m !== want) report($sformatf("matched %0d, expected %0d", m, want));
			end
		endtask
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel, penable, pwrite, pready;
	logic [3:0]        paddr;
	logic [31:0]       pwdata, prdata;
	logic              item_valid, item_ready;
	logic [1:0]        operation;
	logic [5:0]        pattern_index;
	logic [7:0]        pattern_value, mask_value;
	logic [47:0]       adv_address;
	logic signed [7:0] adv_rssi;
	logic [7:0]        adv_length, data_byte;
	logic              result_valid, result_ready, matched;

	verdict_board sb = new();
	int  cycles = 0;
	int  item_count = 0;
	bit  hold_req = 1'b0;
	bit  no_gaps = 1'b0;

	ble_advertisement_filter dut (.*);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// monitor both channels
	always @(posedge clk) begin
		beat_t it;
		if (arst_n) begin
			if (result_valid && result_ready) sb.check(matched);
			if (item_valid && item_ready) begin
				it.op = operation; it.idx = pattern_index; it.pv = pattern_value;
				it.mv = mask_value; it.addr = adv_address; it.rssi = adv_rssi;
				it.len = adv_length; it.db = data_byte;
				sb.note(it);
			end
		end
	end

	// result receiver with random stalls and one long hold-off
	initial begin
		int n;
		result_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				result_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				n = $urandom_range(0, 9);
				if (n < 6) begin
					result_ready <= 1'b1;
					repeat ($urandom_range(0, 20)) @(posedge clk);
				end else if (n < 9) begin
					result_ready <= 1'b0;
					repeat ($urandom_range(0, 3)) @(posedge clk);
				end else begin
					result_ready <= 1'b0;
					repeat ($urandom_range(10, 50)) @(posedge clk);
				end
			end
		end
	end

	function int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// one item beat, held until accepted
	task send(beat_t it);
		int g;
		g = gap_len();
		if (g > 0) begin
			item_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		item_valid <= 1'b1;
		operation <= it.op; pattern_index <= it.idx; pattern_value <= it.pv;
		mask_value <= it.mv; adv_address <= it.addr; adv_rssi <= it.rssi;
		adv_length <= it.len; data_byte <= it.db;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
	endtask

	function beat_t noise_beat(logic [1:0] op);
		beat_t it;
		it.op = op;
		it.idx = $urandom; it.pv = $urandom; it.mv = $urandom;
		it.addr = {$urandom, $urandom}; it.rssi = $urandom;
		it.len = $urandom; it.db = $urandom;
		return it;
	endfunction

	task load_entry(int i, logic [7:0] p, logic [7:0] m);
		beat_t it;
		it = noise_beat(OP_LOAD);
		it.idx = i; it.pv = p; it.mv = m;
		send(it);
		item_count++;
	endtask

	task header(logic [47:0] a, logic signed [7:0] r, logic [7:0] n);
		beat_t it;
		it = noise_beat(OP_HEADER);
		it.addr = a; it.rssi = r; it.len = n;
		send(it);
		item_count++;
	endtask

	task data_bytes(logic [7:0] q [$]);
		beat_t it;
		foreach (q[i]) begin
			it = noise_beat(OP_DATA);
			it.db = q[i];
			send(it);
			item_count++;
		end
	endtask

	// pause the sender until every verdict is in, then let the block settle
	task drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (sb.verdicts.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task reg_write(logic [1:0] r, logic [31:0] v);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {r, 2'b00}; pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0;
		sb.write_reg(r, v);
	endtask

	function logic [47:0] pattern_addr();
		return {sb.pat[5], sb.pat[4], sb.pat[3], sb.pat[2], sb.pat[1], sb.pat[0]};
	endfunction

	// value bytes of one field, shaped after the active mode
	function automatic void field_value(output logic [7:0] kind, ref logic [7:0] v [$]);
		int r, n, w;
		v.delete();
		r = $urandom_range(0, 9);
		if (r >= 7 || sb.mode > MODE_MANUF || sb.mode == MODE_ADDR) begin
			kind = $urandom;
			repeat ($urandom_range(0, 6)) v.push_back($urandom);
			return;
		end
		case (sb.mode)
			MODE_EXACT, MODE_PREFIX: begin
				kind = $urandom_range(0, 1) ? AD_NAME_FULL : AD_NAME_SHORT;
				for (int i = 0; i < sb.plen && i < 64; i++) v.push_back(sb.pat[i]);
				r = $urandom_range(0, 5);
				if (r == 1) repeat ($urandom_range(1, 4)) v.push_back($urandom_range(97, 122));
				if (r == 2 && v.size() > 0) v[$urandom_range(0, v.size() - 1)] ^= 8'h01;
				if (r == 3 && v.size() > 0) v = v[0:$urandom_range(0, v.size() - 1)];
				if (r == 4) begin
					v.push_back(8'h00);
					repeat ($urandom_range(0, 3)) v.push_back($urandom);
				end
			end
			MODE_UUID: begin
				w = $urandom_range(0, 1) ? 16 : 2;
				if (w == 16) kind = $urandom_range(0, 1) ? AD_UUID128_A : AD_UUID128_B;
				else kind = $urandom_range(0, 1) ? AD_UUID16_A : AD_UUID16_B;
				repeat ($urandom_range(1, 3)) begin
					n = $urandom_range(0, 2);
					for (int i = 0; i < w; i++)
						v.push_back(n == 0 ? $urandom : sb.pat[w - 1 - i]);
				end
				if ($urandom_range(0, 3) == 0) v.push_back($urandom);
			end
			default: begin
				kind = AD_MANUF;
				n = sb.plen < 64 ? sb.plen : 64;
				for (int i = 0; i < n; i++)
					v.push_back((sb.pat[i] & sb.msk[i]) | ($urandom & ~sb.msk[i]));
				if ($urandom_range(0, 3) == 0 && v.size() > 0)
					v[$urandom_range(0, v.size() - 1)] ^= 8'($urandom);
				if ($urandom_range(0, 2) == 0) v = v[0:$urandom_range(0, v.size())];
				repeat ($urandom_range(0, 3)) v.push_back($urandom);
			end
		endcase
	endfunction

	// data bytes of one advertisement as length-type-value fields
	function automatic void ad_body(int len, ref logic [7:0] q [$]);
		logic [7:0] v [$];
		logic [7:0] kind;
		int room, r;
		q.delete();
		while (q.size() < len) begin
			room = len - q.size();
			r = $urandom_range(0, 24);
			if (room < 3) begin
				q.push_back($urandom);
			end else if (r == 0) begin
				q.push_back(8'h00);
			end else if (r == 1) begin
				q.push_back(8'($urandom_range(room - 1, 255)));
			end else begin
				field_value(kind, v);
				if (v.size() > room - 2) v = v[0:room - 3];
				if (room - 2 == 0) v.delete();
				q.push_back(8'(v.size() + 1));
				q.push_back(kind);
				foreach (v[i]) q.push_back(v[i]);
			end
		end
	endfunction

	task advertisement();
		logic [7:0] q [$];
		logic signed [7:0] r;
		logic [47:0] a;
		int len, n;
		n = $urandom_range(0, 24);
		if (n == 0) len = $urandom_range(128, 255);
		else if (n < 4) len = 0;
		else len = $urandom_range(1, 31);
		a = (sb.mode == MODE_ADDR && $urandom_range(0, 1)) ? pattern_addr() : {$urandom, $urandom};
		if ($urandom_range(0, 4) == 0) a ^= 48'h1 << $urandom_range(0, 47);
		r = $urandom_range(0, 4) == 0 ? 8'($urandom) :
			8'($urandom_range(sb.rssi_floor + 128, 255) - 128);
		ad_body(len, q);
		header(a, r, len);
		data_bytes(q);
	endtask

	task noise();
		logic [7:0] q [$];
		int r;
		r = $urandom_range(0, 2);
		if (r == 0) begin
			send(noise_beat(OP_DATA));
		end else if (r == 1) begin
			send(noise_beat(2'd3));
		end else begin
			// header abandoned partway by the next one
			ad_body(20, q);
			header({$urandom, $urandom}, $urandom, 20);
			data_bytes(q[0:$urandom_range(0, 15)]);
		end
	endtask

	// new registers and pattern for one phase
	task phase_setup(int ph);
		logic [2:0] m;
		logic [6:0] n;
		logic signed [7:0] mr;
		int r;
		m = ph < 8 ? ph : $urandom_range(0, 7);
		r = $urandom_range(0, 5);
		mr = r == 0 ? -8'sd128 : r == 1 ? 8'sd127 : r == 2 ? 8'($urandom) : -8'sd70;
		case (m)
			MODE_EXACT, MODE_PREFIX: n = $urandom_range(0, 9) == 0 ? 64 : $urandom_range(0, 12);
			MODE_UUID: n = $urandom_range(0, 5) == 0 ? $urandom_range(0, 64) : ($urandom_range(0, 1) ? 2 : 16);
			MODE_MANUF: n = $urandom_range(0, 5) == 0 ? ($urandom_range(0, 1) ? 0 : $urandom_range(33, 64)) : $urandom_range(1, 32);
			default: n = $urandom_range(0, 64);
		endcase
		for (int i = 0; i < (n > 6 ? n : 6); i++) begin
			if (m == MODE_EXACT || m == MODE_PREFIX)
				load_entry(i, $urandom_range(0, 30) == 0 ? 8'h00 : 8'($urandom_range(97, 122)), $urandom);
			else
				load_entry(i, $urandom, $urandom_range(0, 1) ? 8'hff : 8'($urandom));
		end
		drain();
		reg_write(REG_MODE, {$urandom} & ~32'h7 | m);
		reg_write(REG_RSSI, {24'h0, mr});
		reg_write(REG_PLEN, {25'h0, n});
	endtask

	// stimulus
	initial begin
		int ph;
		arst_n = 1'b0;
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
		item_valid <= 1'b0;
		operation <= OP_LOAD; pattern_index <= '0; pattern_value <= '0; mask_value <= '0;
		adv_address <= '0; adv_rssi <= '0; adv_length <= '0; data_byte <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// whole store written before any read
		for (int i = 0; i < PATTERN_DEPTH; i++)
			load_entry(i, i == 0 ? 8'hff : i < 4 ? 8'h61 + i : 8'($urandom), 8'hff);

		// address mode at reset settings, rssi extremes, empty advertisements
		header(pattern_addr(), -8'sd128, 8'd0);
		header(pattern_addr() ^ 48'h8000_0000_0000, 8'sd127, 8'd0);
		send(noise_beat(OP_DATA));
		send(noise_beat(2'd3));
		drain();
		reg_write(REG_RSSI, 32'h7f);
		header(pattern_addr(), 8'sd126, 8'd0);
		header(pattern_addr(), 8'sd127, 8'd0);

		// name exact, then zero length stop, overrun and abandoned header
		load_entry(0, 8'h61, 8'hff);
		drain();
		reg_write(REG_RSSI, 32'h80);
		reg_write(REG_PLEN, 32'd4);
		reg_write(REG_MODE, MODE_EXACT);
		header(48'h0, 8'sd0, 8'd6);
		data_bytes('{8'h05, AD_NAME_FULL, 8'h61, 8'h62, 8'h63, 8'h64});
		header(48'h0, 8'sd0, 8'd4);
		data_bytes('{8'h00, 8'h05, AD_NAME_FULL, 8'h61});
		header(48'h0, 8'sd0, 8'd10);
		data_bytes('{8'h03, AD_NAME_SHORT});
		header(48'h0, 8'sd0, 8'd3);
		data_bytes('{8'h05, AD_NAME_SHORT, 8'h61});

		// random phases
		ph = 0;
		while (item_count < ITEM_GOAL) begin
			phase_setup(ph);
			no_gaps = ($urandom_range(0, 3) == 0);
			if (ph == 3) hold_req = 1'b1;
			repeat ($urandom_range(3, 8)) begin
				if ($urandom_range(0, 7) == 0) noise();
				advertisement();
			end
			ph++;
		end

		drain();
		repeat (20) @(posedge clk);
		while (sb.verdicts.size() != 0) sb.report($sformatf("missing result %0d", sb.verdicts.pop_front()));
		if (sb.errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
